[src/calendar_time_counter_core_macros.svh]
// Assertion macros shared by the calendar time counter checker.
`ifndef CALENDAR_TIME_COUNTER_CORE_MACROS_SVH
`define CALENDAR_TIME_COUNTER_CORE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define CTC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ctc_pkg.sv]
// Package with types, command codes and calendar helpers for the time counter.
package ctc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } time_t;

  typedef struct packed {
    logic [1:0] command;
    time_t      load_time;
  } item_t;

  localparam logic [3:0] MONTH_RESET = 4'd1;
  localparam logic [4:0] DAY_RESET   = 5'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [5:0] SECOND_LAST = 6'd59;

  localparam time_t TIME_RESET = '{month: MONTH_RESET, day: DAY_RESET,
                                   hour: '0, minute: '0, second: '0};

  function automatic logic [4:0] month_length(input logic [3:0] m);
    logic [4:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = 5'd28;
    end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      len = 5'd30;
    end
    return len;
  endfunction

  function automatic logic time_in_range(input time_t t);
    return (t.month != '0) && (t.month <= MONTH_LAST) && (t.day != '0) &&
           (t.hour <= HOUR_LAST) && (t.minute <= MINUTE_LAST) &&
           (t.second <= SECOND_LAST);
  endfunction

endpackage

[src/ctc_if.sv]
// Valid/ready channel interfaces for commands and results of the time counter.
interface ctc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] load_month;
  logic [4:0] load_day;
  logic [4:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_second;

  modport source (output valid, command, load_month, load_day, load_hour,
                  load_minute, load_second, input ready);
  modport sink (input valid, command, load_month, load_day, load_hour,
                load_minute, load_second, output ready);
  modport mon (input valid, ready, command, load_month, load_day, load_hour,
               load_minute, load_second);
endinterface

interface ctc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] month_out;
  logic [4:0] day_out;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [5:0] second_out;
  logic       time_valid;

  modport source (output valid, month_out, day_out, hour_out, minute_out,
                  second_out, time_valid, input ready);
  modport sink (input valid, month_out, day_out, hour_out, minute_out,
                second_out, time_valid, output ready);
  modport mon (input valid, ready, month_out, day_out, hour_out, minute_out,
               second_out, time_valid);
endinterface

[src/calendar_time_counter_core.sv]
// Top level of the month/day/hour/minute/second calendar time counter.
// An accepted command transaction passes through the input register and then
// the result register. Throughput: one transaction per cycle while the result
// side does not stall; each register holds one item, and the next-time logic
// between them is combinational. Reset (synchronous, rst_n low) empties both
// stages and sets January 1, 00:00:00.
module calendar_time_counter_core
  import ctc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  ctc_in_if.sink    in_ch,
  ctc_out_if.source out_ch
);

  // The command transaction is first captured in the input register. In the
  // following cycle the next-time logic reads that item and the current time,
  // and the new time is written both to the time state and to the result
  // register in one step. Both happen only when the result register is free
  // or being emptied, so a stalled result never loses or repeats an update.

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  time_t time_r, time_nxt;
  logic  out_valid_r, out_valid_nxt;
  time_t out_time_r;
  logic  out_ok_r;

  assign in_item.command          = in_ch.command;
  assign in_item.load_time.month  = in_ch.load_month;
  assign in_item.load_time.day    = in_ch.load_day;
  assign in_item.load_time.hour   = in_ch.load_hour;
  assign in_item.load_time.minute = in_ch.load_minute;
  assign in_item.load_time.second = in_ch.load_second;

  // The result register can take a new item when it is empty or is being
  // read in this cycle.
  assign advance = !out_valid_r || out_ch.ready;

  ctc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ctc_next_time u_next_time (
    .cur  (time_r),
    .item (item),
    .nxt  (time_nxt)
  );

  // The result register fills from a held item and drains when the sink
  // takes it; otherwise it keeps what it shows.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = item_valid;
    end
  end

  // The time state is control state: reset puts the calendar at January 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= TIME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance && item_valid) begin
        time_r <= time_nxt;
      end
    end
  end

  // The result payload needs no reset since it is qualified by its valid.
  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_time_r <= time_nxt;
      out_ok_r   <= time_in_range(time_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.month_out  = out_time_r.month;
  assign out_ch.day_out    = out_time_r.day;
  assign out_ch.hour_out   = out_time_r.hour;
  assign out_ch.minute_out = out_time_r.minute;
  assign out_ch.second_out = out_time_r.second;
  assign out_ch.time_valid = out_ok_r;

endmodule

[src/ctc_in_reg.sv]
// Input register: takes one command transaction per cycle unless stalled.
module ctc_in_reg
  import ctc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // The stage refills whenever it is empty or its item moves on this cycle.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[src/ctc_next_time.sv]
// Next-time logic: tick with carries, load, clear; other codes hold time.
module ctc_next_time
  import ctc_pkg::*;
(
  input  time_t cur,
  input  item_t item,
  output time_t nxt
);

  time_t      ticked;
  logic [4:0] len;

  assign len = month_length(cur.month);

  always_comb begin
    ticked = cur;
    if (time_in_range(cur)) begin
      if (cur.second != SECOND_LAST) begin
        ticked.second = cur.second + 6'd1;
      end else begin
        ticked.second = '0;
        if (cur.minute != MINUTE_LAST) begin
          ticked.minute = cur.minute + 6'd1;
        end else begin
          ticked.minute = '0;
          if (cur.hour != HOUR_LAST) begin
            ticked.hour = cur.hour + 5'd1;
          end else begin
            ticked.hour = '0;
            // A day past the end of its month holds and the month stays.
            if (cur.day == len) begin
              ticked.day   = DAY_RESET;
              ticked.month = (cur.month == MONTH_LAST) ? MONTH_RESET
                                                       : cur.month + 4'd1;
            end else if (cur.day < len) begin
              ticked.day = cur.day + 5'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    unique case (cmd_t'(item.command))
      CMD_TICK:  nxt = ticked;
      CMD_LOAD:  nxt = item.load_time;
      CMD_CLEAR: nxt = TIME_RESET;
      default:   nxt = cur;
    endcase
  end

endmodule

[src/ctc_checker.sv]
// Port-level assertion checker for the calendar time counter and its bind.
`include "calendar_time_counter_core_macros.svh"

module ctc_checker
  import ctc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  // The checker sees the channels through the same views the top level holds
  // and only reads them.
  ctc_in_if.sink    in_ch,
  ctc_out_if.source out_ch
);

  // A result that waits must keep its valid and its payload.
  `CTC_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.month_out) && $stable(out_ch.day_out) &&
    $stable(out_ch.hour_out) && $stable(out_ch.minute_out) &&
    $stable(out_ch.second_out) && $stable(out_ch.time_valid),
    "stalled result changed")

  // A month outside one to twelve can never be flagged as a valid time.
  `CTC_ASSERT(a_bad_month, !(out_ch.valid && out_ch.time_valid &&
    (out_ch.month_out == 4'd0 || out_ch.month_out > MONTH_LAST)),
    "valid flag with bad month")

  // A valid flag means every other field is in range as well.
  `CTC_ASSERT(a_fields_ok, !(out_ch.valid && out_ch.time_valid) ||
    (out_ch.day_out != 5'd0 && out_ch.hour_out <= HOUR_LAST &&
    out_ch.minute_out <= MINUTE_LAST && out_ch.second_out <= SECOND_LAST),
    "valid flag with field out of range")

  // With no result pending the input side always has room.
  `CTC_ASSERT_NEXT(a_in_room, !out_ch.valid && !in_ch.valid, in_ch.ready,
    "input stalled while empty")

endmodule

bind calendar_time_counter_core ctc_checker u_ctc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

[test/tb_top.sv]
// Self-checking testbench for the calendar time counter core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  // Command value 3 has no meaning in the block and must leave the time untouched.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The random part stops once this many transactions have gone in after the table.
  localparam int unsigned RANDOM_ITEMS = 1550;
  // Rows in the directed table.
  localparam int unsigned PLAN_ROWS = 25;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 1000;
  // After the last result, the tail gives the block time to show a stray one.
  localparam int unsigned TAIL_CYCLES = 6;

  // One expected result: the time after the command and whether it is in range.
  typedef struct packed {
    time_t now;
    logic  ok;
  } calendar_result_t;

  // One row of the directed table. Rows with typed set carry a hand-written
  // result; the others are checked against the calendar predictor.
  typedef struct {
    logic [1:0]       cmd;
    time_t            load;
    logic             typed;
    calendar_result_t want;
  } plan_row_t;

  // The result receiver cycles through these stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_SPARSE,
    RX_PERIODIC,
    RX_HEAVY
  } rx_pattern_t;

  logic clk;
  logic rst_n;

  ctc_in_if  in_ch ();
  ctc_out_if out_ch ();

  calendar_time_counter_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the time the block should be showing after every command
  // accepted so far, and the results still owed on the output channel.
  time_t            cal_state;
  calendar_result_t pending_times[$];
  plan_row_t        directed_plan [0:PLAN_ROWS-1];

  int unsigned error_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  // Free-running clock with a 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Length of a month in a year with no leap day. Month codes out of 1..12
  // fall through to 31, which only matters for the hold rule and never for
  // an out-of-range time, since those never tick.
  function automatic logic [4:0] days_in_month(input logic [3:0] m);
    case (m)
      4'd2:                   return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  // A day past the end of its month is still considered in range; only a zero
  // day, an illegal month or an overflowing hour, minute or second is not.
  function automatic logic calendar_legal(input time_t t);
    return (t.month != '0) && (t.month <= MONTH_LAST) && (t.day != '0) &&
           (t.hour <= HOUR_LAST) && (t.minute <= MINUTE_LAST) &&
           (t.second <= SECOND_LAST);
  endfunction

  // Time after one command. A tick ripples the carry from seconds upward; when
  // the carry reaches a day that already lies beyond its month end, the day
  // and month hold while the lower fields still wrap.
  function automatic time_t calendar_next(input time_t now, input logic [1:0] cmd,
                                          input time_t load);
    time_t      t;
    logic [4:0] month_len;
    t = now;
    month_len = days_in_month(now.month);
    case (cmd)
      CMD_TICK: begin
        if (calendar_legal(now)) begin
          if (t.second != SECOND_LAST) begin
            t.second = t.second + 6'd1;
          end else begin
            t.second = '0;
            if (t.minute != MINUTE_LAST) begin
              t.minute = t.minute + 6'd1;
            end else begin
              t.minute = '0;
              if (t.hour != HOUR_LAST) begin
                t.hour = t.hour + 5'd1;
              end else begin
                t.hour = '0;
                if (t.day == month_len) begin
                  t.day   = DAY_RESET;
                  t.month = (t.month == MONTH_LAST) ? MONTH_RESET : t.month + 4'd1;
                end else if (t.day < month_len) begin
                  t.day = t.day + 5'd1;
                end
              end
            end
          end
        end
      end
      CMD_LOAD: begin
        t = load;
      end
      CMD_CLEAR: begin
        t = TIME_RESET;
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic time_t stamp(input int unsigned m, input int unsigned d,
                                  input int unsigned h, input int unsigned mi,
                                  input int unsigned s);
    time_t t;
    t.month  = 4'(m);
    t.day    = 5'(d);
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  // Any bit pattern at all; used for loads of arbitrary values and as the
  // ignored payload of ticks, clears and unused commands.
  function automatic time_t random_stamp();
    return time_t'($urandom);
  endfunction

  // A legal time close to a carry: seconds often near 59, often with minute 59,
  // hour 23 and a day at or around the end of the month, so that short runs
  // of ticks reach the minute, hour, day, month and year-end wraps. Now and
  // then the day lies past the month end to exercise the hold rule.
  function automatic time_t near_rollover_stamp();
    time_t       t;
    int unsigned len;
    t.month = 4'($urandom_range(1, 12));
    len = days_in_month(t.month);
    case ($urandom_range(0, 3))
      0:       t.day = 5'(len);
      1:       t.day = 5'(len - 1);
      2:       t.day = 5'((len < 31) ? $urandom_range(len + 1, 31) : len);
      default: t.day = 5'($urandom_range(1, 31));
    endcase
    t.hour   = ($urandom_range(0, 2) != 0) ? HOUR_LAST : 5'($urandom_range(0, 23));
    t.minute = ($urandom_range(0, 2) != 0) ? MINUTE_LAST : 6'($urandom_range(0, 59));
    t.second = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(40, 59))
                                           : 6'($urandom_range(0, 59));
    return t;
  endfunction

  // Drives one command transaction, waits for the handshake, and records
  // what should come back. The sender works in bursts: when a burst runs
  // out, valid drops for a random gap (sometimes none) and a new burst length is drawn.
  // Occasional long bursts give stretches with no idling at all.
  task automatic send_item(input logic [1:0] cmd, input time_t load, input logic typed,
                           input calendar_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.load_month  <= load.month;
    in_ch.load_day    <= load.day;
    in_ch.load_hour   <= load.hour;
    in_ch.load_minute <= load.minute;
    in_ch.load_second <= load.second;
    // Inputs are stable since the falling edge, so ready as seen right after
    // the rising edge decides whether this edge took the transaction.
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cal_state = calendar_next(cal_state, cmd, load);
    if (typed) begin
      pending_times.push_back(want);
    end else begin
      pending_times.push_back('{now: cal_state, ok: calendar_legal(cal_state)});
    end
    items_sent++;
  endtask

  // Ticks carry a random payload so the load fields toggle while ignored.
  task automatic send_tick_run(input int unsigned count);
    repeat (count) send_item(CMD_TICK, random_stamp(), 1'b0, '0);
  endtask

  // Holds the sender off until every owed result has come out.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned pick;
    logic        drained;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.load_month  = '0;
    in_ch.load_day    = '0;
    in_ch.load_hour   = '0;
    in_ch.load_minute = '0;
    in_ch.load_second = '0;
    cal_state         = TIME_RESET;
    drained           = 1'b0;

    // Directed table. The first rows start from the reset time and the year
    // end; then the month ends for February and a 30-day month, a day past
    // the end of its month (which must hold), every kind of out-of-range
    // field including all-ones on every field and all-zeros, the unused
    // command, a clear with a garbage payload, and a plain hour carry.
    directed_plan = '{
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b1, '{stamp(1, 1, 0, 0, 1), 1'b1}},
      '{CMD_LOAD,   stamp(12, 31, 23, 59, 59),  1'b1, '{stamp(12, 31, 23, 59, 59), 1'b1}},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b1, '{stamp(1, 1, 0, 0, 0), 1'b1}},
      '{CMD_LOAD,   stamp(2, 28, 23, 59, 59),   1'b0, '0},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b0, '0},
      '{CMD_LOAD,   stamp(4, 30, 23, 59, 59),   1'b0, '0},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b0, '0},
      '{CMD_LOAD,   stamp(2, 30, 23, 59, 59),   1'b0, '0},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b0, '0},
      '{CMD_LOAD,   stamp(4, 31, 12, 30, 59),   1'b0, '0},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b0, '0},
      '{CMD_LOAD,   stamp(0, 1, 0, 0, 0),       1'b1, '{stamp(0, 1, 0, 0, 0), 1'b0}},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b1, '{stamp(0, 1, 0, 0, 0), 1'b0}},
      '{CMD_LOAD,   stamp(15, 31, 31, 63, 63),  1'b1, '{stamp(15, 31, 31, 63, 63), 1'b0}},
      '{CMD_TICK,   stamp(15, 31, 31, 63, 63),  1'b1, '{stamp(15, 31, 31, 63, 63), 1'b0}},
      '{CMD_LOAD,   stamp(1, 0, 0, 0, 0),       1'b1, '{stamp(1, 0, 0, 0, 0), 1'b0}},
      '{CMD_LOAD,   stamp(1, 1, 24, 0, 0),      1'b1, '{stamp(1, 1, 24, 0, 0), 1'b0}},
      '{CMD_LOAD,   stamp(1, 1, 0, 60, 0),      1'b1, '{stamp(1, 1, 0, 60, 0), 1'b0}},
      '{CMD_LOAD,   stamp(13, 1, 0, 0, 0),      1'b1, '{stamp(13, 1, 0, 0, 0), 1'b0}},
      '{CMD_LOAD,   stamp(1, 1, 0, 0, 60),      1'b1, '{stamp(1, 1, 0, 0, 60), 1'b0}},
      '{CMD_UNUSED, stamp(15, 31, 31, 63, 63),  1'b0, '0},
      '{CMD_CLEAR,  stamp(15, 31, 31, 63, 63),  1'b1, '{TIME_RESET, 1'b1}},
      '{CMD_LOAD,   stamp(6, 15, 10, 59, 59),   1'b0, '0},
      '{CMD_TICK,   stamp(0, 0, 0, 0, 0),       1'b0, '0},
      '{CMD_LOAD,   stamp(0, 0, 0, 0, 0),       1'b1, '{stamp(0, 0, 0, 0, 0), 1'b0}}
    };

    // Synchronous reset is held low from the start and released on a
    // falling edge, away from the edge where the block samples it.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].cmd, directed_plan[i].load, directed_plan[i].typed,
                directed_plan[i].want);
    end

    // Let the pipeline run dry once between the table and the random part.
    wait_for_results();

    // Random part. Most of it is a load of a legal time near a carry followed
    // by a run of ticks, so the carry chain is exercised deeply. The rest is
    // arbitrary loads (mostly out of range), clears and unused commands,
    // each also followed by a few ticks.
    while (items_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      if (!drained && items_sent > PLAN_ROWS + RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_item(CMD_LOAD, near_rollover_stamp(), 1'b0, '0);
        send_tick_run($urandom_range(1, 90));
      end else if (pick < 80) begin
        send_item(CMD_LOAD, random_stamp(), 1'b0, '0);
        send_tick_run($urandom_range(1, 6));
      end else if (pick < 90) begin
        send_item(CMD_CLEAR, random_stamp(), 1'b0, '0);
        send_tick_run($urandom_range(1, 10));
      end else begin
        send_item(CMD_UNUSED, random_stamp(), 1'b0, '0);
        send_tick_run($urandom_range(1, 4));
      end
    end

    // All commands are in; collect the outstanding results, then give the
    // block a few more cycles to show any result it should not produce.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_times.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result receiver
  // ---------------------------------------------------------------------------

  // Periodically the receiver picks a new stall pattern: always ready,
  // ready at random three times in four, a fixed periodic stall pattern,
  // or a coin toss every cycle. The periodic pattern drifts against the
  // sender's bursts, so stalls land on every phase of the pipeline.
  initial begin
    rx_pattern_t rx_mode;
    int unsigned rx_count;
    out_ch.ready = 1'b0;
    rx_mode      = RX_ALWAYS;
    rx_count     = 0;
    forever begin
      @(negedge clk);
      if (rx_count % 48 == 0) begin
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
      end
      rx_count++;
      case (rx_mode)
        RX_ALWAYS:   out_ch.ready <= 1'b1;
        RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ch.ready <= ((rx_count % 7) >= 3);
        default:     out_ch.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  // Each result transaction is matched against the oldest expectation, field
  // by field. A result with nothing owed is itself a failure.
  always @(posedge clk) begin
    calendar_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_times.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        want = pending_times.pop_front();
        if (out_ch.month_out !== want.now.month) begin
          report_mismatch("month_out", out_ch.month_out, want.now.month);
        end
        if (out_ch.day_out !== want.now.day) begin
          report_mismatch("day_out", out_ch.day_out, want.now.day);
        end
        if (out_ch.hour_out !== want.now.hour) begin
          report_mismatch("hour_out", out_ch.hour_out, want.now.hour);
        end
        if (out_ch.minute_out !== want.now.minute) begin
          report_mismatch("minute_out", out_ch.minute_out, want.now.minute);
        end
        if (out_ch.second_out !== want.now.second) begin
          report_mismatch("second_out", out_ch.second_out, want.now.second);
        end
        if (out_ch.time_valid !== want.ok) begin
          report_mismatch("time_valid", out_ch.time_valid, want.ok);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  // Counts cycles in which neither channel completes a transaction. The
  // longest legal quiet stretch is a sender gap plus a receiver stall, far
  // below the limit, so reaching it means the block has hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
